>>> src/byte_fifo_with_peek_skip_macros.svh
// Assertion macros for the byte FIFO with peek and skip.
// No dependencies; taken in by `include where assertions are written.
`ifndef BYTE_FIFO_WITH_PEEK_SKIP_MACROS_SVH
`define BYTE_FIFO_WITH_PEEK_SKIP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication: antecedent and consequent checked on the same edge.
`define BFPS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bfps assertion failed");
// Next-cycle implication: antecedent and consequent checked on successive edges.
`define BFPS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bfps assertion failed");
`else
`define BFPS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BFPS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> src/bfps_pkg.sv
// Shared types and constants for the byte FIFO with peek and skip.
// No dependencies; imported by the top level.
package bfps_pkg;

    localparam int DEPTH_DEFAULT = 1024;
    localparam int BYTE_W        = 8;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_READ  = 2'd1,
        ACT_PEEK  = 2'd2,
        ACT_SKIP  = 2'd3
    } action_t;

endpackage

>>> src/bfps_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies; read data holds until the next read enable.
module bfps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic [ADDR_W-1:0] addr,
    input  logic              we,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/byte_fifo_with_peek_skip.sv
// Top level of the circular byte FIFO with peek and skip.
// Depends on bfps_pkg, bfps_ram and byte_fifo_with_peek_skip_macros.svh.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------
//  s_      | in        | s_valid / s_ready   | s_action, s_wr_byte, s_count
//  m_      | out       | m_valid / m_ready   | m_rd_byte, m_ok, m_fill_level, m_skipped
//
// One transaction is taken per cycle while results drain; each result passes
// through the storage RAM's registered read, held in the pending stage, and
// then through the output register before it leaves.
// Pointers and occupancy update at acceptance, so back-to-back actions see
// each other's effect with no forwarding: a write lands before any later read.
// Reset clears pointers, occupancy and valids only; the storage RAM is not
// cleared, since only occupied (already written) entries are ever read.
// A stalled output holds the pending stage, which in turn drops s_ready.
// DEPTH must be a power of two; count, fill level and skipped are
// $clog2(DEPTH)+1 bits wide.
module byte_fifo_with_peek_skip #(
    parameter int DEPTH = bfps_pkg::DEPTH_DEFAULT,
    localparam int ADDR_W = $clog2(DEPTH),
    localparam int CNT_W  = ADDR_W + 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  bfps_pkg::action_t             s_action,
    input  logic [bfps_pkg::BYTE_W-1:0]   s_wr_byte,
    input  logic [CNT_W-1:0]              s_count,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bfps_pkg::BYTE_W-1:0]   m_rd_byte,
    output logic                          m_ok,
    output logic [CNT_W-1:0]              m_fill_level,
    output logic [CNT_W-1:0]              m_skipped
);

    import bfps_pkg::*;

    `include "byte_fifo_with_peek_skip_macros.svh"

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    // Result fields known at acceptance; the byte itself comes from the RAM.
    typedef struct packed {
        logic             use_data;
        logic             ok;
        logic [CNT_W-1:0] fill;
        logic [CNT_W-1:0] skipped;
    } meta_t;

    // FIFO state
    logic [ADDR_W-1:0] wp_reg, wp_next;
    logic [ADDR_W-1:0] rp_reg, rp_next;
    logic [CNT_W-1:0]  occ_reg, occ_next;

    // Pending stage: waits for RAM read data
    logic  p_valid_reg, p_valid_next;
    meta_t p_meta_reg, p_meta_next;

    // Output register
    logic                m_valid_reg, m_valid_next;
    logic                m_ok_reg;
    logic [BYTE_W-1:0]   m_rd_byte_reg;
    logic [CNT_W-1:0]    m_fill_reg;
    logic [CNT_W-1:0]    m_skipped_reg;

    // RAM port
    logic [ADDR_W-1:0] ram_addr;
    logic              ram_we;
    logic              ram_re;
    logic [BYTE_W-1:0] ram_rdata;

    logic              s_accept;
    logic              p_adv;
    logic              full;
    logic              empty;
    logic              peek_ok;
    logic [CNT_W-1:0]  skip_n;

    // Advance the pending stage whenever the output register is free or drains.
    assign p_adv    = p_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !p_valid_reg || p_adv;
    assign s_accept = s_valid && s_ready;

    assign full    = (occ_reg == DEPTH_CNT);
    assign empty   = (occ_reg == '0);
    assign peek_ok = (s_count < occ_reg);
    assign skip_n  = peek_ok ? s_count : occ_reg;

    // Decode the action against the current state, before any update.
    always_comb begin
        wp_next     = wp_reg;
        rp_next     = rp_reg;
        occ_next    = occ_reg;
        ram_addr    = rp_reg;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        p_meta_next = p_meta_reg;

        if (s_accept) begin
            p_meta_next.use_data = 1'b0;
            p_meta_next.ok       = 1'b0;
            p_meta_next.skipped  = '0;
            case (s_action)
                ACT_WRITE: begin
                    // drop the byte when full
                    ram_addr = wp_reg;
                    if (!full) begin
                        ram_we              = 1'b1;
                        wp_next             = wp_reg + 1'b1;
                        occ_next            = occ_reg + 1'b1;
                        p_meta_next.ok      = 1'b1;
                    end
                end
                ACT_READ: begin
                    ram_addr = rp_reg;
                    if (!empty) begin
                        ram_re               = 1'b1;
                        rp_next              = rp_reg + 1'b1;
                        occ_next             = occ_reg - 1'b1;
                        p_meta_next.ok       = 1'b1;
                        p_meta_next.use_data = 1'b1;
                    end
                end
                ACT_PEEK: begin
                    // offset is below occupancy, so the low bits address the slot
                    ram_addr = rp_reg + s_count[ADDR_W-1:0];
                    if (peek_ok) begin
                        ram_re               = 1'b1;
                        p_meta_next.ok       = 1'b1;
                        p_meta_next.use_data = 1'b1;
                    end
                end
                ACT_SKIP: begin
                    // skipping the whole depth leaves the pointer where it was
                    rp_next             = rp_reg + skip_n[ADDR_W-1:0];
                    occ_next            = occ_reg - skip_n;
                    p_meta_next.ok      = 1'b1;
                    p_meta_next.skipped = skip_n;
                end
                default: begin
                    p_meta_next.ok = 1'b0;
                end
            endcase
            p_meta_next.fill = occ_next;
        end
    end

    always_comb begin
        p_valid_next = p_valid_reg;
        if (s_accept) begin
            p_valid_next = 1'b1;
        end else if (p_adv) begin
            p_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (p_adv) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg      <= '0;
            rp_reg      <= '0;
            occ_reg     <= '0;
            p_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            wp_reg      <= wp_next;
            rp_reg      <= rp_next;
            occ_reg     <= occ_next;
            p_valid_reg <= p_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        p_meta_reg <= p_meta_next;
        if (p_adv) begin
            m_ok_reg      <= p_meta_reg.ok;
            m_fill_reg    <= p_meta_reg.fill;
            m_skipped_reg <= p_meta_reg.skipped;
            m_rd_byte_reg <= p_meta_reg.use_data ? ram_rdata : '0;
        end
    end

    bfps_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_storage (
        .aclk  (aclk),
        .addr  (ram_addr),
        .we    (ram_we),
        .wdata (s_wr_byte),
        .re    (ram_re),
        .rdata (ram_rdata)
    );

    assign m_valid      = m_valid_reg;
    assign m_rd_byte    = m_rd_byte_reg;
    assign m_ok         = m_ok_reg;
    assign m_fill_level = m_fill_reg;
    assign m_skipped    = m_skipped_reg;

    // Pointer distance always matches the occupancy count.
    `BFPS_ASSERT_IMP(a_ptr_occ, aclk, aresetn, 1'b1, (ADDR_W'(wp_reg - rp_reg) == occ_reg[ADDR_W-1:0]) && (occ_reg <= DEPTH_CNT))
    // A held pending result blocks new transactions.
    `BFPS_ASSERT_IMP(a_stall_block, aclk, aresetn, p_valid_reg && !p_adv, !s_ready)
    // A write refused while full leaves the FIFO untouched.
    `BFPS_ASSERT_NXT(a_full_drop, aclk, aresetn, s_accept && (s_action == ACT_WRITE) && full, $stable(occ_reg) && $stable(wp_reg) && !p_meta_reg.ok)
    // A read accepted on a non-empty FIFO lowers the occupancy by one.
    `BFPS_ASSERT_NXT(a_read_dec, aclk, aresetn, s_accept && (s_action == ACT_READ) && !empty, occ_reg == $past(occ_reg) - 1'b1)

endmodule
